// ----- rtl/ftprlp_pkg.sv -----
// Package for the FTP reply line parser: codes, characters and result type.
package ftprlp_pkg;

  typedef enum logic [1:0] {
    CODE_START  = 2'd0,
    CODE_DIGITS = 2'd1,
    CODE_SPACE  = 2'd2,
    CODE_BAD    = 2'd3
  } code_phase_t;

  localparam logic [1:0] REG_EXPECTED_CODE = 2'd0;
  localparam logic [1:0] REG_REPORT_LINES  = 2'd1;

  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_RPAREN = 8'h29;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;

  localparam logic [15:0] CODE_MAX      = 16'hFFFF;
  localparam logic [15:0] CODE_FINAL    = 16'd400;
  localparam logic [8:0]  FIELD_SAT     = 9'd256;
  localparam logic [8:0]  FIELD_MAX     = 9'd255;
  localparam int          MIN_CODE_LINE = 4;

  localparam logic KIND_LINE     = 1'b0;
  localparam logic KIND_OVERFLOW = 1'b1;

  typedef struct packed {
    logic [15:0] pasv_port;
    logic        pasv_valid;
    logic        forward_line;
    logic        done_res;
    logic [15:0] status_code;
    logic        code_found;
    logic [7:0]  line_length;
  } result_t;

endpackage

// ----- rtl/ftp_reply_line_parser_unit.sv -----
// FTP reply line parser: splits reply bytes into lines and reports code and passive port.
// A result is registered and appears on the output the cycle after its line's last byte.
// Throughput: one byte per cycle while the output is not stalled; all line state updates
// in a single register stage. The output register refills in the cycle it is taken, so
// the input stalls only on output backpressure. Synchronous active-high reset clears
// line state and the output valid, and sets expected_code to 0 and report_lines to 1.
module ftp_reply_line_parser_unit #(
  parameter int BUFFER_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] line_length, [8] code_found, [24:9] status_code,
                                 // [25] done_res, [26] forward_line, [27] pasv_valid,
                                 // [43:28] pasv_port, [47:44] zero
  output logic        m_tuser,   // [0] kind
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(BUFFER_BYTES);
  localparam int LW = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] COUNT_LIMIT = CW'(BUFFER_BYTES - 1);
  localparam logic [CW-1:0] COUNT_CODE  = CW'(ftprlp_pkg::MIN_CODE_LINE);

  logic [9:0]  expected_code;
  logic        report_lines;

  logic                    after_cr, after_cr_next;
  logic [CW-1:0]           line_count, line_count_next;
  logic [15:0]             code_value, code_value_next;
  ftprlp_pkg::code_phase_t code_phase, code_phase_next;
  logic [8:0]              field_value, field_value_next;
  logic                    field_digits_only, field_digits_only_next;
  logic [8:0]              prior_field_value, prior_field_value_next;
  logic                    prior_field_ok, prior_field_ok_next;
  logic                    comma_seen, comma_seen_next;
  logic                    paren_ok, paren_ok_next;
  logic [15:0]             paren_port, paren_port_next;

  logic                 accept;
  logic                 digit;
  logic [3:0]           dval;
  logic [CW-1:0]        count_inc;
  logic [LW-1:0]        count_ext;
  logic [19:0]          code_mul;
  logic [12:0]          field_mul;
  logic                 line_end;
  logic                 overflow;
  logic                 found;
  logic [15:0]          code_sel;
  logic                 has_result;
  logic                 res_kind;
  ftprlp_pkg::result_t  res;
  ftprlp_pkg::result_t  out_res;
  logic                 out_kind;

  assign pready   = 1'b1;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_code <= '0;
      report_lines  <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      case ({1'b0, paddr[2]})
        ftprlp_pkg::REG_EXPECTED_CODE: expected_code <= pwdata[9:0];
        ftprlp_pkg::REG_REPORT_LINES:  report_lines  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case ({1'b0, paddr[2]})
      ftprlp_pkg::REG_EXPECTED_CODE: prdata = {22'd0, expected_code};
      ftprlp_pkg::REG_REPORT_LINES:  prdata = {31'd0, report_lines};
      default:                       prdata = '0;
    endcase
  end

  always_comb begin
    after_cr_next          = after_cr;
    code_value_next        = code_value;
    code_phase_next        = code_phase;
    field_value_next       = field_value;
    field_digits_only_next = field_digits_only;
    prior_field_value_next = prior_field_value;
    prior_field_ok_next    = prior_field_ok;
    comma_seen_next        = comma_seen;
    paren_ok_next          = paren_ok;
    paren_port_next        = paren_port;

    digit     = s_tdata inside {[8'h30:8'h39]};
    dval      = 4'(s_tdata - ftprlp_pkg::CHAR_ZERO);
    count_inc = line_count + CW'(1);
    count_ext = LW'(count_inc);
    line_count_next = count_inc;
    after_cr_next   = (s_tdata == ftprlp_pkg::CHAR_CR);
    line_end  = (s_tdata == ftprlp_pkg::CHAR_LF) && after_cr;
    code_mul  = {code_value, 3'b000} + {3'b000, code_value, 1'b0} + 20'(dval);
    field_mul = {field_value, 3'b000} + {3'b000, field_value, 1'b0} + 13'(dval);

    case (code_phase)
      ftprlp_pkg::CODE_START: begin
        code_phase_next = digit ? ftprlp_pkg::CODE_DIGITS : ftprlp_pkg::CODE_BAD;
        code_value_next = digit ? 16'(dval) : 16'd0;
      end
      ftprlp_pkg::CODE_DIGITS: begin
        if (digit) begin
          code_value_next = (code_mul > 20'(ftprlp_pkg::CODE_MAX)) ?
                            ftprlp_pkg::CODE_MAX : code_mul[15:0];
        end else if (s_tdata == ftprlp_pkg::CHAR_SPACE) begin
          code_phase_next = ftprlp_pkg::CODE_SPACE;
        end else begin
          code_phase_next = ftprlp_pkg::CODE_BAD;
        end
      end
      default: ;
    endcase

    if (digit) begin
      field_value_next = (field_mul > 13'(ftprlp_pkg::FIELD_SAT)) ?
                         ftprlp_pkg::FIELD_SAT : field_mul[8:0];
    end else if (s_tdata == ftprlp_pkg::CHAR_COMMA) begin
      prior_field_ok_next    = comma_seen && field_digits_only;
      prior_field_value_next = field_value;
      comma_seen_next        = (line_count != '0);
      field_value_next       = '0;
      field_digits_only_next = 1'b1;
      paren_ok_next          = 1'b0;
    end else begin
      if (s_tdata == ftprlp_pkg::CHAR_RPAREN) begin
        if (prior_field_ok && field_digits_only &&
            field_value <= ftprlp_pkg::FIELD_MAX &&
            prior_field_value <= ftprlp_pkg::FIELD_MAX) begin
          paren_ok_next   = 1'b1;
          paren_port_next = {prior_field_value[7:0], field_value[7:0]};
        end else begin
          paren_ok_next   = 1'b0;
          paren_port_next = '0;
        end
      end
      field_digits_only_next = 1'b0;
    end

    overflow = count_inc >= COUNT_LIMIT;
    found    = (code_phase_next == ftprlp_pkg::CODE_SPACE) && (count_inc >= COUNT_CODE);
    code_sel = found ? code_value_next : 16'd0;

    res = '0;
    res.line_length = count_ext[7:0];
    res_kind = ftprlp_pkg::KIND_OVERFLOW;
    if (line_end) begin
      res_kind         = ftprlp_pkg::KIND_LINE;
      res.code_found   = found;
      res.status_code  = code_sel;
      res.done_res     = found && (code_sel != 16'd0) &&
                         ((code_sel == {6'd0, expected_code}) ||
                          (code_sel >= ftprlp_pkg::CODE_FINAL) ||
                          (expected_code == 10'd0));
      res.forward_line = report_lines;
      res.pasv_valid   = paren_ok_next;
      res.pasv_port    = paren_ok_next ? paren_port_next : 16'd0;
    end
    has_result = line_end || overflow;

    if (has_result) begin
      after_cr_next          = 1'b0;
      line_count_next        = '0;
      code_value_next        = '0;
      code_phase_next        = ftprlp_pkg::CODE_START;
      field_value_next       = '0;
      field_digits_only_next = 1'b1;
      prior_field_value_next = '0;
      prior_field_ok_next    = 1'b0;
      comma_seen_next        = 1'b0;
      paren_ok_next          = 1'b0;
      paren_port_next        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      after_cr          <= 1'b0;
      line_count        <= '0;
      code_value        <= '0;
      code_phase        <= ftprlp_pkg::CODE_START;
      field_value       <= '0;
      field_digits_only <= 1'b1;
      prior_field_value <= '0;
      prior_field_ok    <= 1'b0;
      comma_seen        <= 1'b0;
      paren_ok          <= 1'b0;
      paren_port        <= '0;
    end else if (accept) begin
      after_cr          <= after_cr_next;
      line_count        <= line_count_next;
      code_value        <= code_value_next;
      code_phase        <= code_phase_next;
      field_value       <= field_value_next;
      field_digits_only <= field_digits_only_next;
      prior_field_value <= prior_field_value_next;
      prior_field_ok    <= prior_field_ok_next;
      comma_seen        <= comma_seen_next;
      paren_ok          <= paren_ok_next;
      paren_port        <= paren_port_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && has_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      out_res  <= res;
      out_kind <= res_kind;
    end
  end

  assign m_tdata = {4'd0, out_res};
  assign m_tuser = out_kind;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    line_count < COUNT_LIMIT)
    else $error("line count reached buffer limit");

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    accept && has_result |=> line_count == '0 && !after_cr &&
                             code_phase == ftprlp_pkg::CODE_START)
    else $error("line state not cleared after result");

  a_overflow_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[47:8] == '0)
    else $error("overflow result carries nonzero fields");

  a_pasv_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[27] |-> m_tdata[43:28] == 16'd0)
    else $error("passive port nonzero without valid");

  a_code_found: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[8] |-> m_tdata[25:9] == '0)
    else $error("status code or done set without found code");

endmodule
